// File: rtl/core/hse_pkg.sv
// hse_pkg: sizes, types and codes shared by the hash set engine
// no dependencies; used by hse_divider and hash_set_engine
package hse_pkg;

   localparam int NUM_BUCKETS  = 64;
   localparam int WAYS         = 4;
   localparam int SLOT_TOTAL   = NUM_BUCKETS * WAYS;
   localparam int RESET_BUCKET_COUNT = 16;

   localparam int DATA_W  = 32;
   localparam int CSR_W   = 7;
   localparam int BCNT_W  = $clog2(NUM_BUCKETS + 1);
   localparam int BKT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int SLOT_W  = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
   localparam int COUNT_W = $clog2(SLOT_TOTAL + 1);
   localparam int SCAN_W  = $clog2(WAYS + 1);
   localparam int STEP_W  = $clog2(DATA_W);

   typedef logic [DATA_W-1:0]  data_type;
   typedef logic [BCNT_W-1:0]  bcnt_type;
   typedef logic [BKT_W-1:0]   bkt_type;
   typedef logic [SLOT_W-1:0]  slot_idx_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [SCAN_W-1:0]  scan_type;
   typedef logic [STEP_W-1:0]  step_type;

   // operation codes on req_kind; the fourth code is a no-op
   localparam logic [1:0] KIND_ADD      = 2'd0;
   localparam logic [1:0] KIND_REMOVE   = 2'd1;
   localparam logic [1:0] KIND_CONTAINS = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/core/hse_ram.sv
// hse_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
module hse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/hse_divider.sv
// hse_divider: restoring divider, one quotient bit a cycle, remainder only
// depends on hse_pkg
module hse_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  hse_pkg::data_type dividend,
   input  hse_pkg::bcnt_type divisor,
   output logic              done,
   output hse_pkg::bcnt_type remainder
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   hse_pkg::step_type step_ff, step_in;
   hse_pkg::data_type quo_ff, quo_in;
   hse_pkg::bcnt_type rem_ff, rem_in;
   logic [hse_pkg::BCNT_W:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, quo_ff[hse_pkg::DATA_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[hse_pkg::DATA_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         // partial remainder stays below the divisor, so the difference fits
         if (trial >= {1'b0, divisor}) begin
            rem_in = hse_pkg::bcnt_type'(trial - {1'b0, divisor});
         end else begin
            rem_in = hse_pkg::bcnt_type'(trial);
         end
         if (step_ff == hse_pkg::step_type'(hse_pkg::DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/core/hash_set_engine.sv
// hash_set_engine: bucketed set of signed 32-bit values, add, remove, contains
// depends on hse_pkg, hse_divider and hse_ram
//
//  port group     direction  handshake
//  req_*, start   in         taken when start is high and busy is low
//  rsp_*          out        one-cycle strobe rsp_valid, no back-pressure
//  csr_*          in         written when csr_write_en is high
//
// a transaction runs from acceptance to rsp_valid through the bit-serial modulo in
// hse_divider (32 steps and the done flag), a scan of the bucket through the registered
// slot RAM read and a last state that decides, updates and loads the result register;
// the next transaction can be taken in the cycle rsp_valid is shown.
// busy rises in the cycle after acceptance and is low again in the cycle rsp_valid is shown.
// reset clears the valid marks, the count and sets bucket_count to 16; no clearing pass.
// the receiver cannot stall, so results never wait.
module hash_set_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_kind,
   input  logic signed [31:0]        req_value,
   output logic                      rsp_valid,
   output logic                      rsp_result_flag,
   output logic                      rsp_bucket_full,
   output logic [8:0]                rsp_element_count,
   input  logic                      csr_write_en,
   input  logic [6:0]                csr_write_data
);

   hse_pkg::state_type    state_ff, state_in;
   hse_pkg::bcnt_type     bucket_count_ff, bucket_count_in;
   logic [1:0]            kind_ff, kind_in;
   hse_pkg::data_type     value_ff, value_in;
   hse_pkg::slot_idx_type base_ff, base_in;
   hse_pkg::scan_type     scan_ff, scan_in;
   logic                  hit_ff, hit_in;
   hse_pkg::slot_idx_type hit_idx_ff, hit_idx_in;
   logic                  free_ff, free_in;
   hse_pkg::slot_idx_type free_idx_ff, free_idx_in;
   logic [hse_pkg::SLOT_TOTAL-1:0] valid_ff, valid_in;
   hse_pkg::count_type    count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_flag_ff, rsp_flag_in;
   logic                  rsp_full_ff, rsp_full_in;
   hse_pkg::count_type    rsp_count_ff, rsp_count_in;

   logic                  accept;
   hse_pkg::data_type     magnitude;
   logic                  div_done;
   hse_pkg::bcnt_type     div_rem;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   hse_pkg::slot_idx_type ram_rd_addr;
   hse_pkg::data_type     ram_rd_data;
   hse_pkg::slot_idx_type cmp_idx;

   assign accept = start && (state_ff == hse_pkg::ST_IDLE);
   // magnitude as unsigned, so the most negative value maps to 2^31
   assign magnitude = req_value[31] ? hse_pkg::data_type'(-req_value)
                                    : hse_pkg::data_type'(req_value);

   hse_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (magnitude),
      .divisor   (bucket_count_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   hse_ram #(
      .WIDTH (hse_pkg::DATA_W),
      .DEPTH (hse_pkg::SLOT_TOTAL)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (free_idx_ff),
      .wr_data (value_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // config clamp: zero becomes one, anything above the table size saturates
   always_comb begin
      bucket_count_in = bucket_count_ff;
      if (csr_write_en) begin
         if (csr_write_data == '0) begin
            bucket_count_in = hse_pkg::bcnt_type'(1);
         end else if (int'(csr_write_data) > hse_pkg::NUM_BUCKETS) begin
            bucket_count_in = hse_pkg::bcnt_type'(hse_pkg::NUM_BUCKETS);
         end else begin
            bucket_count_in = hse_pkg::bcnt_type'(csr_write_data);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      value_in     = value_ff;
      base_in      = base_ff;
      scan_in      = scan_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_flag_in  = rsp_flag_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_count_in = rsp_count_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = base_ff + hse_pkg::slot_idx_type'(scan_ff);
      cmp_idx      = base_ff + hse_pkg::slot_idx_type'(scan_ff - 1'b1);

      case (state_ff)
         hse_pkg::ST_IDLE: begin
            if (accept) begin
               kind_in  = req_kind;
               value_in = hse_pkg::data_type'(req_value);
               state_in = hse_pkg::ST_DIV;
            end
         end
         hse_pkg::ST_DIV: begin
            if (div_done) begin
               base_in  = hse_pkg::slot_idx_type'(
                  hse_pkg::bkt_type'(div_rem) * hse_pkg::WAYS);
               scan_in  = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = hse_pkg::ST_SCAN;
            end
         end
         hse_pkg::ST_SCAN: begin
            // read of one way overlaps the compare of the previous way
            ram_rd_en = (int'(scan_ff) < hse_pkg::WAYS);
            if (scan_ff != '0) begin
               if (valid_ff[cmp_idx]) begin
                  if (!hit_ff && ram_rd_data == value_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = cmp_idx;
                  end
               end else if (!free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cmp_idx;
               end
            end
            scan_in = scan_ff + 1'b1;
            if (int'(scan_ff) == hse_pkg::WAYS) begin
               state_in = hse_pkg::ST_FINISH;
            end
         end
         hse_pkg::ST_FINISH: begin
            rsp_flag_in = 1'b0;
            rsp_full_in = 1'b0;
            case (kind_ff)
               hse_pkg::KIND_ADD: begin
                  if (!hit_ff) begin
                     if (free_ff) begin
                        ram_wr_en             = 1'b1;
                        valid_in[free_idx_ff] = 1'b1;
                        count_in              = count_ff + 1'b1;
                        rsp_flag_in           = 1'b1;
                     end else begin
                        rsp_full_in = 1'b1;
                     end
                  end
               end
               hse_pkg::KIND_REMOVE: begin
                  if (hit_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                     rsp_flag_in = 1'b1;
                  end
               end
               hse_pkg::KIND_CONTAINS: begin
                  rsp_flag_in = hit_ff;
               end
               default: begin
               end
            endcase
            rsp_count_in = count_in;
            rsp_valid_in = 1'b1;
            state_in     = hse_pkg::ST_IDLE;
         end
         default: begin
            state_in = hse_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= hse_pkg::ST_IDLE;
         bucket_count_ff <= hse_pkg::bcnt_type'(hse_pkg::RESET_BUCKET_COUNT);
         valid_ff        <= '0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         scan_ff         <= '0;
         hit_ff          <= 1'b0;
         free_ff         <= 1'b0;
      end else begin
         state_ff        <= state_in;
         bucket_count_ff <= bucket_count_in;
         valid_ff        <= valid_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
         scan_ff         <= scan_in;
         hit_ff          <= hit_in;
         free_ff         <= free_in;
      end
      kind_ff      <= kind_in;
      value_ff     <= value_in;
      base_ff      <= base_in;
      hit_idx_ff   <= hit_idx_in;
      free_idx_ff  <= free_idx_in;
      rsp_flag_ff  <= rsp_flag_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy              = (state_ff != hse_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_flag   = rsp_flag_ff;
   assign rsp_bucket_full   = rsp_full_ff;
   assign rsp_element_count = 9'(rsp_count_ff);

   // a refused add never also reports success
   a_full_excludes_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_full_ff && rsp_flag_ff))
      else $error("bucket_full and result_flag both set");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= hse_pkg::SLOT_TOTAL)
      else $error("element count above table size");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // the stored count only moves with a finished transaction
   a_count_moves_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |-> rsp_valid_ff)
      else $error("element count changed without a result");

endmodule
